// ===== rtl/stc_pkg.sv =====
`timescale 1ns / 1ps

package stc_pkg;

    // opcode values
    localparam logic OP_SINE   = 1'b0;
    localparam logic OP_COSINE = 1'b1;

    // fixed-point internal format: 30 fraction bits
    localparam int Q_FRAC = 30;
    localparam int MAG_W  = 32;   // |x| <= pi
    localparam int X2_W   = 34;   // x*x <= pi^2
    localparam int K_W    = 28;   // 1/((n-1)n), largest at n = 3
    localparam int C_W    = 31;   // x*x*K <= pi^2/6
    localparam int TM_W   = 34;   // term magnitude, largest is pi^3/6
    localparam int SUM_W  = 40;
    localparam int PROD_W = 66;

    localparam logic [33:0] PI_Q30      = 34'd3373259426;
    localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
    localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;

    localparam logic [PROD_W-1:0] ROUND_HALF = 66'd536870912;

    // round to nearest (halves up on magnitudes) and drop the fraction
    function automatic logic [PROD_W-Q_FRAC-1:0] qround(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] s;
        s = p + ROUND_HALF;
        return s[PROD_W-1:Q_FRAC];
    endfunction

    // round(2^30 / ((n-1)*n)) for n = 2*idx + 3
    function automatic logic [K_W-1:0] k_coef(input int idx);
        logic [K_W-1:0] k;
        case (idx)
            0:       k = 28'd178956971;
            1:       k = 28'd53687091;
            2:       k = 28'd25565282;
            3:       k = 28'd14913081;
            4:       k = 28'd9761289;
            5:       k = 28'd6882960;
            6:       k = 28'd5113056;
            7:       k = 28'd3947580;
            8:       k = 28'd3139596;
            9:       k = 28'd2556528;
            10:      k = 28'd2122019;
            11:      k = 28'd1789570;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/stc_reduce.sv =====
`timescale 1ns / 1ps

module stc_reduce #(
    parameter int ANGLE_FRAC_BITS = 28
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [31:0]               angle,
    input  logic                      opcode,
    output logic                      out_valid,
    output logic                      out_neg,
    output logic [stc_pkg::MAG_W-1:0] out_mag
);

    localparam int SHIFT = stc_pkg::Q_FRAC - ANGLE_FRAC_BITS;
    localparam int ANG_W = 32 + SHIFT + 3;

    localparam logic signed [ANG_W-1:0] PI_S      = ANG_W'(stc_pkg::PI_Q30);
    localparam logic signed [ANG_W-1:0] NEG_PI_S  = -PI_S;
    localparam logic signed [ANG_W-1:0] HALF_PI_S = ANG_W'(stc_pkg::HALF_PI_Q30);
    localparam logic signed [ANG_W-1:0] TWO_PI_S  = ANG_W'(stc_pkg::TWO_PI_Q30);

    logic                    v1_reg;
    logic signed [ANG_W-1:0] a1_reg;
    logic signed [ANG_W-1:0] a1_next;
    logic                    v2_reg;
    logic                    neg_reg;
    logic                    neg_next;
    logic [stc_pkg::MAG_W-1:0] mag_reg;
    logic [stc_pkg::MAG_W-1:0] mag_next;

    // first half: widen, cosine offset, bring down from above
    always_comb
    begin
        logic signed [ANG_W-1:0] a;
        a = $signed({{(ANG_W-32){angle[31]}}, angle}) <<< SHIFT;
        if (opcode == stc_pkg::OP_COSINE)
        begin
            a = HALF_PI_S - a;
        end
        if (a > PI_S)
        begin
            a = a - TWO_PI_S;
        end
        if (a > PI_S)
        begin
            a = a - TWO_PI_S;
        end
        a1_next = a;
    end

    // second half: bring up from below, clamp, split sign and magnitude
    always_comb
    begin
        logic signed [ANG_W-1:0] a;
        logic signed [ANG_W-1:0] m;
        a = a1_reg;
        if (a < NEG_PI_S)
        begin
            a = a + TWO_PI_S;
        end
        if (a < NEG_PI_S)
        begin
            a = a + TWO_PI_S;
        end
        if (a > PI_S)
        begin
            a = PI_S;
        end
        if (a < NEG_PI_S)
        begin
            a = NEG_PI_S;
        end
        m        = a[ANG_W-1] ? -a : a;
        neg_next = a[ANG_W-1];
        mag_next = m[stc_pkg::MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= a1_next;
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_neg   = neg_reg;
    assign out_mag   = mag_reg;

endmodule

// ===== rtl/stc_coef.sv =====
`timescale 1ns / 1ps

module stc_coef #(
    parameter int TERMS = 9
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic                                   in_neg,
    input  logic [stc_pkg::MAG_W-1:0]              in_mag,
    output logic                                   out_valid,
    output logic                                   out_neg,
    output logic [stc_pkg::TM_W-1:0]               out_mag,
    output logic [TERMS-1:0][stc_pkg::C_W-1:0]     out_coef
);

    logic                        v1_reg;
    logic                        neg1_reg;
    logic [stc_pkg::MAG_W-1:0]   mag1_reg;
    logic [stc_pkg::X2_W-1:0]    x2_reg;
    logic [stc_pkg::X2_W-1:0]    x2_next;
    logic                        v2_reg;
    logic                        neg2_reg;
    logic [stc_pkg::MAG_W-1:0]   mag2_reg;
    logic [TERMS-1:0][stc_pkg::C_W-1:0] coef_reg;
    logic [TERMS-1:0][stc_pkg::C_W-1:0] coef_next;

    always_comb
    begin
        logic [2*stc_pkg::MAG_W-1:0] sq;
        sq      = in_mag * in_mag;
        x2_next = stc_pkg::X2_W'(stc_pkg::qround(stc_pkg::PROD_W'(sq)));
    end

    // x^2 / ((n-1)n) for every term, all in parallel
    for (genvar j = 0; j < TERMS; j++)
    begin : g_coef
        localparam logic [stc_pkg::K_W-1:0] KJ = stc_pkg::k_coef(j);
        logic [stc_pkg::X2_W+stc_pkg::K_W-1:0] p;
        assign p            = x2_reg * KJ;
        assign coef_next[j] = stc_pkg::C_W'(stc_pkg::qround(stc_pkg::PROD_W'(p)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= in_neg;
            mag1_reg <= in_mag;
            x2_reg   <= x2_next;
            neg2_reg <= neg1_reg;
            mag2_reg <= mag1_reg;
            coef_reg <= coef_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_neg   = neg2_reg;
    assign out_mag   = stc_pkg::TM_W'(mag2_reg);
    assign out_coef  = coef_reg;

endmodule

// ===== rtl/stc_term.sv =====
`timescale 1ns / 1ps

module stc_term #(
    parameter int TERMS = 9,
    parameter int IDX   = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic                                   in_neg,
    input  logic [stc_pkg::TM_W-1:0]               in_mag,
    input  logic signed [stc_pkg::SUM_W-1:0]       in_sum,
    input  logic [TERMS-1:0][stc_pkg::C_W-1:0]     in_coef,
    output logic                                   out_valid,
    output logic                                   out_neg,
    output logic [stc_pkg::TM_W-1:0]               out_mag,
    output logic signed [stc_pkg::SUM_W-1:0]       out_sum,
    output logic [TERMS-1:0][stc_pkg::C_W-1:0]     out_coef
);

    // term signs alternate, starting from the sign of x
    localparam logic ODD = 1'(IDX % 2);

    logic                              valid_reg;
    logic                              neg_reg;
    logic [stc_pkg::TM_W-1:0]          mag_reg;
    logic [stc_pkg::TM_W-1:0]          mag_next;
    logic signed [stc_pkg::SUM_W-1:0]  sum_reg;
    logic signed [stc_pkg::SUM_W-1:0]  sum_next;
    logic [TERMS-1:0][stc_pkg::C_W-1:0] coef_reg;

    always_comb
    begin
        logic signed [stc_pkg::TM_W:0]         t;
        logic [stc_pkg::TM_W+stc_pkg::C_W-1:0] p;
        t = $signed({1'b0, in_mag});
        if (in_neg ^ ODD)
        begin
            t = -t;
        end
        sum_next = in_sum + $signed({{(stc_pkg::SUM_W-stc_pkg::TM_W-1){t[stc_pkg::TM_W]}}, t});
        p        = in_mag * in_coef[IDX];
        mag_next = stc_pkg::TM_W'(stc_pkg::qround(stc_pkg::PROD_W'(p)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg  <= in_neg;
            mag_reg  <= mag_next;
            sum_reg  <= sum_next;
            coef_reg <= in_coef;
        end
    end

    assign out_valid = valid_reg;
    assign out_neg   = neg_reg;
    assign out_mag   = mag_reg;
    assign out_sum   = sum_reg;
    assign out_coef  = coef_reg;

endmodule

// ===== rtl/sine_cosine_taylor.sv =====
`timescale 1ns / 1ps

// Sine / cosine of a fixed-point angle by truncated Taylor series.
// Request channel: in_valid / in_stall with angle (signed, ANGLE_FRAC_BITS
// fraction bits) and opcode (0 = sine, 1 = cosine).
// Result channel: out_valid / out_stall with value (signed Q2.30, saturated).
// A request or result moves on a rising edge where valid is high and stall low.
// The pipeline stages, in order: angle reduction (first and second half), x^2,
// the per-term coefficients x^2/((n-1)n), a stage per term
// (one 34x31 multiply each) and the last add and saturation.
// Throughput is one request per cycle except while out_stall freezes the pipeline, which has no loops.
// All stages advance together; when the output holds a result and out_stall
// is high the whole pipeline freezes and in_stall is raised, so nothing is
// dropped or repeated. Otherwise a new request is taken every cycle even while
// a result is being presented.
// Reset clears all valid bits; the pipeline is empty and ready right after.
module sine_cosine_taylor #(
    parameter int TERMS           = 9,
    parameter int ANGLE_FRAC_BITS = 28
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] angle,
    input  logic               opcode,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value
);

    localparam logic LAST_ODD = 1'(TERMS % 2);
    localparam logic signed [31:0] VALUE_BOUND = 32'sd1090519040;

    logic en;

    logic                        x_valid;
    logic                        x_neg;
    logic [stc_pkg::MAG_W-1:0]   x_mag;

    logic [TERMS:0]                                 t_valid;
    logic [TERMS:0]                                 t_neg;
    logic [TERMS:0][stc_pkg::TM_W-1:0]              t_mag;
    logic signed [stc_pkg::SUM_W-1:0]               t_sum [TERMS+1];
    logic [TERMS:0][TERMS-1:0][stc_pkg::C_W-1:0]    t_coef;

    logic                 valid_reg;
    logic signed [31:0]   value_reg;
    logic signed [31:0]   value_next;

    assign en       = !(valid_reg && out_stall);
    assign in_stall = !en;

    stc_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .angle    (angle),
        .opcode   (opcode),
        .out_valid(x_valid),
        .out_neg  (x_neg),
        .out_mag  (x_mag)
    );

    stc_coef #(
        .TERMS(TERMS)
    ) u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (x_valid),
        .in_neg   (x_neg),
        .in_mag   (x_mag),
        .out_valid(t_valid[0]),
        .out_neg  (t_neg[0]),
        .out_mag  (t_mag[0]),
        .out_coef (t_coef[0])
    );

    assign t_sum[0] = '0;

    for (genvar j = 0; j < TERMS; j++)
    begin : g_term
        stc_term #(
            .TERMS(TERMS),
            .IDX  (j)
        ) u_term (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (t_valid[j]),
            .in_neg   (t_neg[j]),
            .in_mag   (t_mag[j]),
            .in_sum   (t_sum[j]),
            .in_coef  (t_coef[j]),
            .out_valid(t_valid[j+1]),
            .out_neg  (t_neg[j+1]),
            .out_mag  (t_mag[j+1]),
            .out_sum  (t_sum[j+1]),
            .out_coef (t_coef[j+1])
        );
    end

    // add the last term, then saturate to Q2.30
    always_comb
    begin
        logic signed [stc_pkg::TM_W:0]    t;
        logic signed [stc_pkg::SUM_W-1:0] s;
        logic [stc_pkg::SUM_W-32:0]       hi;
        t = $signed({1'b0, t_mag[TERMS]});
        if (t_neg[TERMS] ^ LAST_ODD)
        begin
            t = -t;
        end
        s  = t_sum[TERMS] + $signed({{(stc_pkg::SUM_W-stc_pkg::TM_W-1){t[stc_pkg::TM_W]}}, t});
        hi = s[stc_pkg::SUM_W-1:31];
        if ((&hi) || !(|hi))
        begin
            value_next = s[31:0];
        end
        else if (s[stc_pkg::SUM_W-1])
        begin
            value_next = 32'sh8000_0000;
        end
        else
        begin
            value_next = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= t_valid[TERMS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
        end
    end

    assign out_valid = valid_reg;
    assign value     = value_reg;

`ifndef SYNTHESIS
    // reduced angle never leaves [-pi, pi]
    a_reduced_range: assert property (@(posedge clk) disable iff (!rst_n)
        x_valid |-> ({2'b00, x_mag} <= stc_pkg::PI_Q30))
        else $error("reduced angle above pi");

    // a frozen pipeline keeps its term stages as they are
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(t_valid))
        else $error("term stages moved while stalled");

    // series stays close to [-1, 1] for any reduced angle
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (value <= VALUE_BOUND) && (value >= -VALUE_BOUND))
        else $error("series result out of range");
`endif

endmodule
